// ----- rtl/um_register_alu_execute_defines.svh -----
// Assertion macros shared by the execute unit and its iterative arithmetic unit.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef UM_REGISTER_ALU_EXECUTE_DEFINES_SVH
`define UM_REGISTER_ALU_EXECUTE_DEFINES_SVH

// Expression must hold on every clock edge outside reset.
`define UM_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define UM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define UM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/umrae_pkg.sv -----
// Shared types and constants of the register ALU execute unit.
// Depends on nothing; the iterative unit, the top level and the testbench import it.
package umrae_pkg;

  localparam int WORD_W    = 32;
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 3;
  localparam int OP_W      = 4;
  localparam int OPND_W    = 28;
  localparam int BYTE_W    = 8;
  localparam int IMM_W     = 25;
  localparam int STATUS_W  = 3;
  localparam int CNT_W     = $clog2(WORD_W);

  typedef enum logic [OP_W-1:0] {
    OP_CMOV = 4'd0,
    OP_ADD  = 4'd3,
    OP_MUL  = 4'd4,
    OP_DIV  = 4'd5,
    OP_NAND = 4'd6,
    OP_HALT = 4'd7,
    OP_OUT  = 4'd10,
    OP_IN   = 4'd11,
    OP_LOAD = 4'd13
  } umrae_op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 3'd0,
    STS_HALTED    = 3'd1,
    STS_DIV_ZERO  = 3'd2,
    STS_OUT_RANGE = 3'd3,
    STS_BAD_OP    = 3'd4
  } umrae_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WAIT,
    ST_PUT
  } umrae_state_t;

  typedef enum logic [1:0] {
    MODE_ADD,
    MODE_MUL,
    MODE_DIV
  } umrae_mode_t;

  // Request from the sequencer to the iterative arithmetic unit.
  typedef struct packed {
    logic        start;
    umrae_mode_t mode;
  } umrae_ctl_t;

  // One complete result word.
  typedef struct packed {
    logic                 out_vld;
    logic [BYTE_W-1:0]    out_byte;
    logic                 wen;
    logic [REG_IDX_W-1:0] widx;
    logic [WORD_W-1:0]    wval;
    umrae_status_t        status;
  } umrae_res_t;

endpackage

// ----- rtl/umrae_ram.sv -----
// Generic register-file RAM: one write port, two read ports with registered data.
// Depends on nothing.
module umrae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- rtl/umrae_iter_unit.sv -----
// Iterative arithmetic unit: one shared adder/subtractor does add in one step,
// multiply and divide in one bit per step. Depends on umrae_pkg and the defines header.
`include "um_register_alu_execute_defines.svh"

module umrae_iter_unit
  import umrae_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  umrae_ctl_t        ctl,
  input  logic [WORD_W-1:0] opa,
  input  logic [WORD_W-1:0] opb,
  output logic              done,
  output logic [WORD_W-1:0] result
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  umrae_mode_t       mode_r, mode_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic [WORD_W-1:0] aux_r, aux_nxt;
  logic [WORD_W-1:0] sh_r, sh_nxt;

  logic [WORD_W:0]   add_x, add_y;
  logic              add_sub;
  logic [WORD_W+1:0] add_sum;
  logic              last_step;

  // The one shared adder. In subtract mode the top bit is the no-borrow flag.
  always_comb begin
    case (mode_r)
      MODE_DIV: begin
        add_x   = {acc_r, aux_r[WORD_W-1]};
        add_y   = {1'b0, sh_r};
        add_sub = 1'b1;
      end
      MODE_MUL: begin
        add_x   = {1'b0, acc_r};
        add_y   = sh_r[0] ? {1'b0, aux_r} : '0;
        add_sub = 1'b0;
      end
      default: begin
        add_x   = {1'b0, acc_r};
        add_y   = {1'b0, sh_r};
        add_sub = 1'b0;
      end
    endcase
    add_sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
            + (WORD_W+2)'(add_sub);
  end

  assign last_step = (mode_r == MODE_ADD) || (cnt_r == CNT_W'(WORD_W - 1));

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    aux_nxt  = aux_r;
    sh_nxt   = sh_r;
    if (!busy_r && ctl.start) begin
      busy_nxt = 1'b1;
      mode_nxt = ctl.mode;
      cnt_nxt  = '0;
      acc_nxt  = (ctl.mode == MODE_ADD) ? opa : '0;
      aux_nxt  = opa;
      sh_nxt   = opb;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      case (mode_r)
        MODE_DIV: begin
          // Restoring division: keep the difference only when it did not borrow.
          acc_nxt = add_sum[WORD_W+1] ? add_sum[WORD_W-1:0] : add_x[WORD_W-1:0];
          aux_nxt = {aux_r[WORD_W-2:0], add_sum[WORD_W+1]};
        end
        MODE_MUL: begin
          acc_nxt = add_sum[WORD_W-1:0];
          aux_nxt = {aux_r[WORD_W-2:0], 1'b0};
          sh_nxt  = {1'b0, sh_r[WORD_W-1:1]};
        end
        default: begin
          acc_nxt = add_sum[WORD_W-1:0];
        end
      endcase
      if (last_step) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      mode_r <= MODE_ADD;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    aux_r <= aux_nxt;
    sh_r  <= sh_nxt;
  end

  assign done   = done_r;
  assign result = (mode_r == MODE_DIV) ? aux_r : acc_r;

  `UM_ASSERT_IMPL(a_no_start_busy, ctl.start, !busy_r, "start requested while unit busy")
  `UM_ASSERT_NEXT(a_done_after_last, busy_r && last_step, done_r && !busy_r, "last step did not finish")
  `UM_ASSERT_NEXT(a_cnt_step, busy_r && !last_step, cnt_r == $past(cnt_r) + CNT_W'(1), "step count skipped")

endmodule

// ----- rtl/um_register_alu_execute.sv -----
// Top level of the register ALU execute unit of the 32-bit Universal Machine.
// Depends on umrae_pkg, umrae_ram, umrae_iter_unit and the defines header.
`include "um_register_alu_execute_defines.svh"

// This block executes one Universal Machine instruction per input word against
// eight 32-bit registers and returns exactly one result word for each. The
// register file sits in a small two-read-port RAM, with eight valid bits that are
// cleared by reset, so an unwritten register reads as zero without a clearing
// pass. A word is taken on the cycle after the previous one leaves the
// sequencer; the sequencer reads registers B and C as it takes the word.
// Conditional move, NAND, halt, output, input, load and rejected opcodes finish
// straight from the execute state. Add, multiply and divide go through one
// shared adder/subtractor stepped by its own counter: multiply and divide
// produce one bit of the product or quotient per cycle over 32 steps, and divide
// by zero is caught before the unit starts. A finished result is held
// in an output register, so the block takes the next instruction while that
// result waits; if the output is stalled and a second result is ready, the
// sequencer holds it and stops taking words until the output register frees.
// After a halt instruction every further word reports the halted status and
// changes nothing, until reset.
module um_register_alu_execute
  import umrae_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Instruction channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OP_W-1:0]      in_op,
  input  logic [OPND_W-1:0]    in_operand_bits,
  input  logic [BYTE_W-1:0]    in_in_byte,
  input  logic                 in_in_end,
  // Result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_out_valid,
  output logic [BYTE_W-1:0]    out_out_byte,
  output logic                 out_write_en,
  output logic [REG_IDX_W-1:0] out_write_index,
  output logic [WORD_W-1:0]    out_write_value,
  output logic [STATUS_W-1:0]  out_status
);

  umrae_state_t         state_r, state_nxt;
  logic                 halted_r, halted_nxt;
  logic [NUM_REGS-1:0]  vld_r, vld_nxt;
  logic                 out_vld_r, out_vld_nxt;
  umrae_res_t           res_out_r;
  umrae_res_t           res_r, res_nxt;

  // Instruction word captured on acceptance.
  logic [OP_W-1:0]      op_r;
  logic [OPND_W-1:0]    bits_r;
  logic [BYTE_W-1:0]    byte_r;
  logic                 end_r;

  logic [REG_IDX_W-1:0] raddr_b, raddr_c;
  logic [WORD_W-1:0]    rdata_b, rdata_c;
  logic                 vld_b_r, vld_c_r;
  logic [WORD_W-1:0]    vb, vc;

  logic [REG_IDX_W-1:0] ra_r, rc_r;

  umrae_ctl_t           ctl;
  logic                 unit_done;
  logic [WORD_W-1:0]    unit_result;

  umrae_res_t           exec_res;
  logic                 exec_iter;
  umrae_mode_t          exec_mode;
  logic                 fin;
  umrae_res_t           fin_res;
  logic                 out_free;
  logic                 commit;
  logic                 ram_we;

  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_vld_r || !out_stall;

  // While idle the registers of the arriving word are read, afterwards those of
  // the held word, so the read data stay put for the whole instruction.
  assign raddr_b = (state_r == ST_IDLE) ? in_operand_bits[5:3] : bits_r[5:3];
  assign raddr_c = (state_r == ST_IDLE) ? in_operand_bits[2:0] : bits_r[2:0];
  assign ra_r    = bits_r[8:6];
  assign rc_r    = bits_r[2:0];

  umrae_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_REGS)
  ) u_regfile (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (fin_res.widx),
    .wdata   (fin_res.wval),
    .raddr_a (raddr_b),
    .rdata_a (rdata_b),
    .raddr_b (raddr_c),
    .rdata_b (rdata_c)
  );

  // A register never written since reset reads as zero.
  assign vb = rdata_b & {WORD_W{vld_b_r}};
  assign vc = rdata_c & {WORD_W{vld_c_r}};

  umrae_iter_unit u_iter (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .opa    (vb),
    .opb    (vc),
    .done   (unit_done),
    .result (unit_result)
  );

  // Decode and the operations that need no iterative unit.
  always_comb begin
    exec_res        = '0;
    exec_res.status = STS_OK;
    exec_iter       = 1'b0;
    exec_mode       = MODE_ADD;
    if (halted_r) begin
      exec_res.status = STS_HALTED;
    end else begin
      case (umrae_op_t'(op_r))
        OP_CMOV: begin
          if (vc != '0) begin
            exec_res.wen  = 1'b1;
            exec_res.widx = ra_r;
            exec_res.wval = vb;
          end
        end
        OP_ADD: begin
          exec_iter = 1'b1;
          exec_mode = MODE_ADD;
        end
        OP_MUL: begin
          exec_iter = 1'b1;
          exec_mode = MODE_MUL;
        end
        OP_DIV: begin
          if (vc == '0) begin
            exec_res.status = STS_DIV_ZERO;
          end else begin
            exec_iter = 1'b1;
            exec_mode = MODE_DIV;
          end
        end
        OP_NAND: begin
          exec_res.wen  = 1'b1;
          exec_res.widx = ra_r;
          exec_res.wval = ~(vb & vc);
        end
        OP_HALT: begin
          exec_res.status = STS_HALTED;
        end
        OP_OUT: begin
          if (vc[WORD_W-1:BYTE_W] != '0) begin
            exec_res.status = STS_OUT_RANGE;
          end else begin
            exec_res.out_vld  = 1'b1;
            exec_res.out_byte = vc[BYTE_W-1:0];
          end
        end
        OP_IN: begin
          exec_res.wen  = 1'b1;
          exec_res.widx = rc_r;
          exec_res.wval = end_r ? '1 : {{(WORD_W-BYTE_W){1'b0}}, byte_r};
        end
        OP_LOAD: begin
          exec_res.wen  = 1'b1;
          exec_res.widx = bits_r[OPND_W-1:IMM_W];
          exec_res.wval = {{(WORD_W-IMM_W){1'b0}}, bits_r[IMM_W-1:0]};
        end
        default: begin
          exec_res.status = STS_BAD_OP;
        end
      endcase
    end
  end

  // Sequencer: a result is committed to the output register and the register
  // file in the same cycle, or parked in res_r until the output frees up.
  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    ctl       = '0;
    fin       = 1'b0;
    fin_res   = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_iter) begin
          ctl.start = 1'b1;
          ctl.mode  = exec_mode;
          state_nxt = ST_WAIT;
        end else begin
          fin     = 1'b1;
          fin_res = exec_res;
        end
      end
      ST_WAIT: begin
        if (unit_done) begin
          fin            = 1'b1;
          fin_res.wen    = 1'b1;
          fin_res.widx   = ra_r;
          fin_res.wval   = unit_result;
          fin_res.status = STS_OK;
        end
      end
      ST_PUT: begin
        fin     = 1'b1;
        fin_res = res_r;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    commit = fin && out_free;
    if (fin) begin
      if (commit) begin
        state_nxt = ST_IDLE;
      end else begin
        state_nxt = ST_PUT;
        res_nxt   = fin_res;
      end
    end
  end

  assign ram_we = commit && fin_res.wen;

  always_comb begin
    vld_nxt = vld_r;
    if (ram_we) begin
      vld_nxt[fin_res.widx] = 1'b1;
    end
    halted_nxt  = halted_r || (commit && (fin_res.status == STS_HALTED));
    out_vld_nxt = commit || (out_vld_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      halted_r  <= 1'b0;
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      halted_r  <= halted_nxt;
      vld_r     <= vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r   <= res_nxt;
    vld_b_r <= vld_r[raddr_b];
    vld_c_r <= vld_r[raddr_c];
    if (commit) begin
      res_out_r <= fin_res;
    end
    if (in_valid && !in_stall) begin
      op_r   <= in_op;
      bits_r <= in_operand_bits;
      byte_r <= in_in_byte;
      end_r  <= in_in_end;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_out_valid   = res_out_r.out_vld;
  assign out_out_byte    = res_out_r.out_byte;
  assign out_write_en    = res_out_r.wen;
  assign out_write_index = res_out_r.widx;
  assign out_write_value = res_out_r.wval;
  assign out_status      = res_out_r.status;

  `UM_ASSERT_NEXT(a_halt_sticky, halted_r, halted_r, "halted flag cleared without reset")
  `UM_ASSERT_IMPL(a_halt_status, commit && halted_r, fin_res.status == STS_HALTED, "result after halt not reported as halted")
  `UM_ASSERT_IMPL(a_wr_busy, ram_we, state_r != ST_IDLE, "register write while idle")
  `UM_ASSERT_IMPL(a_out_clean, out_vld_r && !res_out_r.wen, res_out_r.widx == '0 && res_out_r.wval == '0, "unused write fields not zero")

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the Universal Machine register ALU execute unit.
// Depends on umrae_pkg and um_register_alu_execute; needs no files or arguments.
// An in-bench copy of the architectural registers predicts every result word.
module tb;
  import umrae_pkg::*;

  // Opcodes that the unit rejects: the four array opcodes, load program and
  // the two codes that the machine leaves undefined.
  localparam logic [OP_W-1:0] OP_ARR_INDEX = 4'd1;
  localparam logic [OP_W-1:0] OP_ARR_AMEND = 4'd2;
  localparam logic [OP_W-1:0] OP_ALLOC     = 4'd8;
  localparam logic [OP_W-1:0] OP_ABANDON   = 4'd9;
  localparam logic [OP_W-1:0] OP_LOAD_PROG = 4'd12;
  localparam logic [OP_W-1:0] OP_UNDEF_E   = 4'd14;
  localparam logic [OP_W-1:0] OP_UNDEF_F   = 4'd15;
  localparam logic [6:0][OP_W-1:0] UNSUPPORTED_OPS = {OP_ARR_INDEX, OP_ARR_AMEND, OP_ALLOC,
                                                      OP_ABANDON, OP_LOAD_PROG, OP_UNDEF_E,
                                                      OP_UNDEF_F};

  localparam logic [WORD_W-1:0] BYTE_MAX = 32'd255;
  localparam int RANDOM_WORDS = 600;
  // Cycles without any handshake before the run is declared hung. Multiply and
  // divide are the slowest words; this leaves a wide margin for long stall runs.
  localparam int QUIET_LIMIT = 4000;
  // Cycles allowed after the last result for a stray extra word to show up.
  localparam int TAIL_CYCLES = 40;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      in_op = '0;
  logic [OPND_W-1:0]    in_operand_bits = '0;
  logic [BYTE_W-1:0]    in_in_byte = '0;
  logic                 in_in_end = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_out_valid;
  logic [BYTE_W-1:0]    out_out_byte;
  logic                 out_write_en;
  logic [REG_IDX_W-1:0] out_write_index;
  logic [WORD_W-1:0]    out_write_value;
  logic [STATUS_W-1:0]  out_status;

  // Architectural state as the testbench believes it to be after every
  // accepted instruction word.
  logic [WORD_W-1:0] arch_regs [NUM_REGS];
  logic              arch_halted = 1'b0;

  umrae_res_t pending_results [$];
  umrae_res_t want_res;
  int         mismatch_count = 0;
  int         result_count = 0;
  int         quiet_cycles = 0;
  // While set, neither side inserts idle cycles or stalls.
  logic       steady = 1'b0;

  um_register_alu_execute i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_operand_bits (in_operand_bits),
    .in_in_byte      (in_in_byte),
    .in_in_end       (in_in_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_out_valid   (out_out_valid),
    .out_out_byte    (out_out_byte),
    .out_write_en    (out_write_en),
    .out_write_index (out_write_index),
    .out_write_value (out_write_value),
    .out_status      (out_status)
  );

  always #6 clk = ~clk;

  initial begin
    for (int r = 0; r < NUM_REGS; r++) arch_regs[r] = '0;
  end

  // Executes one instruction word on the architectural copy and returns the
  // result word that the unit must produce for it.
  function automatic umrae_res_t execute_insn(input logic [OP_W-1:0] op,
                                              input logic [OPND_W-1:0] bits,
                                              input logic [BYTE_W-1:0] byte_in,
                                              input logic end_in);
    umrae_res_t           res;
    logic [REG_IDX_W-1:0] dest;
    logic [WORD_W-1:0]    vb;
    logic [WORD_W-1:0]    vc;
    logic [WORD_W-1:0]    value;
    logic                 writes;
    res    = '0;
    dest   = bits[8:6];
    vb     = arch_regs[bits[5:3]];
    vc     = arch_regs[bits[2:0]];
    value  = '0;
    writes = 1'b1;
    // Once halted, the unit reports the halted status and touches nothing.
    if (arch_halted) begin
      res.status = STS_HALTED;
      return res;
    end
    case (op)
      OP_CMOV: begin
        writes = (vc != '0);
        value  = vb;
      end
      OP_ADD:  value = vb + vc;
      OP_MUL:  value = vb * vc;
      OP_DIV: begin
        if (vc == '0) begin
          writes     = 1'b0;
          res.status = STS_DIV_ZERO;
        end else begin
          value = vb / vc;
        end
      end
      OP_NAND: value = ~(vb & vc);
      OP_HALT: begin
        arch_halted = 1'b1;
        writes      = 1'b0;
        res.status  = STS_HALTED;
      end
      OP_OUT: begin
        writes = 1'b0;
        if (vc > BYTE_MAX) begin
          res.status = STS_OUT_RANGE;
        end else begin
          res.out_vld  = 1'b1;
          res.out_byte = vc[BYTE_W-1:0];
        end
      end
      OP_IN: begin
        dest  = bits[2:0];
        value = end_in ? '1 : WORD_W'(byte_in);
      end
      OP_LOAD: begin
        dest  = bits[OPND_W-1 -: REG_IDX_W];
        value = WORD_W'(bits[IMM_W-1:0]);
      end
      default: begin
        writes     = 1'b0;
        res.status = STS_BAD_OP;
      end
    endcase
    if (writes) begin
      arch_regs[dest] = value;
      res.wen  = 1'b1;
      res.widx = dest;
      res.wval = value;
    end
    return res;
  endfunction

  function automatic logic [OPND_W-1:0] abc(input logic [REG_IDX_W-1:0] a,
                                            input logic [REG_IDX_W-1:0] b,
                                            input logic [REG_IDX_W-1:0] c);
    return {{(OPND_W-3*REG_IDX_W){1'b0}}, a, b, c};
  endfunction

  function automatic logic [OPND_W-1:0] load_bits(input logic [REG_IDX_W-1:0] r,
                                                  input logic [IMM_W-1:0] imm);
    return {r, imm};
  endfunction

  // Picks a register whose current value is at most the bound, or any
  // register when none qualifies.
  function automatic logic [REG_IDX_W-1:0] pick_reg(input logic [WORD_W-1:0] bound);
    int hits [$];
    for (int r = 0; r < NUM_REGS; r++) begin
      if (arch_regs[r] <= bound) hits.push_back(r);
    end
    if (hits.size() == 0) return REG_IDX_W'($urandom_range(0, NUM_REGS-1));
    return REG_IDX_W'(hits[$urandom_range(0, hits.size()-1)]);
  endfunction

  // Offers one instruction word, holding it steady until the unit takes it,
  // and records the expected result at the edge where it is accepted. The
  // stall is looked at on the falling edge, where nothing is in motion.
  task automatic send_insn(input logic [OP_W-1:0] op, input logic [OPND_W-1:0] bits,
                           input logic [BYTE_W-1:0] byte_in, input logic end_in);
    while (!steady && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_operand_bits <= bits;
    in_in_byte      <= byte_in;
    in_in_end       <= end_in;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    pending_results.push_back(execute_insn(op, bits, byte_in, end_in));
  endtask

  // Withdraws the instruction stream until every outstanding result is back.
  task automatic await_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Prints one line for a mismatch and counts it.
  task automatic report_mismatch(input string field, input logic [WORD_W-1:0] want,
                                 input logic [WORD_W-1:0] got);
    $display("result word %0d: %s expected 0x%0h, got 0x%0h", result_count, field,
             want, got);
    mismatch_count++;
  endtask

  // Loads: the largest 25-bit immediate, a byte at the limit of the output
  // range and one just above it.
  task automatic test_load_immediates();
    send_insn(OP_LOAD, load_bits(3'd1, '1), 8'h00, 1'b0);
    send_insn(OP_LOAD, load_bits(3'd7, IMM_W'(BYTE_MAX)), 8'hFF, 1'b1);
    send_insn(OP_LOAD, load_bits(3'd6, IMM_W'(BYTE_MAX + 1)), 8'h00, 1'b0);
  endtask

  // Arithmetic at the extremes: NAND of zero gives all ones (with every unused
  // operand bit set), add and multiply wrap at 32 bits, divide and divide by
  // zero.
  task automatic test_arithmetic();
    send_insn(OP_NAND, {{(OPND_W-9){1'b1}}, 3'd3, 3'd0, 3'd0}, 8'h00, 1'b0);
    send_insn(OP_ADD,  abc(3'd4, 3'd3, 3'd3), 8'h00, 1'b0);
    send_insn(OP_MUL,  abc(3'd5, 3'd3, 3'd3), 8'h00, 1'b0);
    send_insn(OP_DIV,  abc(3'd4, 3'd3, 3'd1), 8'h00, 1'b0);
    send_insn(OP_DIV,  abc(3'd5, 3'd1, 3'd0), 8'h00, 1'b0);
  endtask

  // Conditional move with a zero condition writes nothing; a nonzero one does.
  task automatic test_cond_move();
    send_insn(OP_CMOV, abc(3'd2, 3'd1, 3'd0), 8'h00, 1'b0);
    send_insn(OP_CMOV, abc(3'd2, 3'd1, 3'd7), 8'h00, 1'b0);
  endtask

  // Output of 255 and of 0, output above a byte, input of a byte and input at
  // end of stream, where the offered byte must be ignored.
  task automatic test_byte_io();
    send_insn(OP_OUT, abc(3'd0, 3'd0, 3'd7), 8'h00, 1'b0);
    send_insn(OP_OUT, abc(3'd0, 3'd0, 3'd0), 8'h00, 1'b0);
    send_insn(OP_OUT, abc(3'd0, 3'd0, 3'd6), 8'h00, 1'b0);
    send_insn(OP_IN,  abc(3'd0, 3'd0, 3'd4), 8'hA5, 1'b0);
    send_insn(OP_IN,  abc(3'd0, 3'd0, 3'd5), 8'h5A, 1'b1);
  endtask

  task automatic test_unsupported_ops();
    for (int k = 0; k < 7; k++) begin
      send_insn(UNSUPPORTED_OPS[k], OPND_W'($urandom), 8'($urandom), 1'($urandom));
    end
  endtask

  // Mostly well-formed instructions with random registers, steered so that
  // outputs often fall in range and divides and moves sometimes see zero.
  // Halfway through the sender waits for a full drain, and one stretch runs
  // with no idling on either side.
  task automatic test_random_stream();
    int                pick;
    logic [OP_W-1:0]   op;
    logic [OPND_W-1:0] bits;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 2) await_drain();
      steady <= (n >= 400 && n < 500);
      pick = $urandom_range(0, 99);
      bits = OPND_W'($urandom);
      if (pick < 15) begin
        op = OP_LOAD;
        if ($urandom_range(0, 1) == 0) bits[IMM_W-1:0] = IMM_W'($urandom_range(0, 300));
      end else if (pick < 27) op = OP_ADD;
      else if (pick < 37) op = OP_MUL;
      else if (pick < 47) op = OP_DIV;
      else if (pick < 57) op = OP_NAND;
      else if (pick < 67) op = OP_CMOV;
      else if (pick < 77) op = OP_OUT;
      else if (pick < 87) op = OP_IN;
      else if (pick < 94) op = UNSUPPORTED_OPS[$urandom_range(0, 6)];
      else begin
        op = OP_W'($urandom_range(0, 15));
        if (op == OP_HALT) op = OP_NAND;
      end
      if (op == OP_OUT && $urandom_range(0, 9) < 7) bits[2:0] = pick_reg(BYTE_MAX);
      if ((op == OP_DIV || op == OP_CMOV) && $urandom_range(0, 3) == 0) begin
        bits[2:0] = pick_reg('0);
      end
      send_insn(op, bits, 8'($urandom), $urandom_range(0, 3) == 0);
    end
    steady <= 1'b0;
  endtask

  // Halt comes last since only reset clears it: afterwards every word of any
  // kind must report the halted status and change nothing.
  task automatic test_halt();
    send_insn(OP_HALT, OPND_W'($urandom), 8'($urandom), 1'b0);
    send_insn(OP_LOAD, load_bits(3'd0, IMM_W'(5)), 8'h00, 1'b0);
    send_insn(OP_OUT,  abc(3'd0, 3'd0, 3'd7), 8'h00, 1'b0);
    send_insn(OP_ADD,  abc(3'd1, 3'd3, 3'd3), 8'h00, 1'b0);
    send_insn(OP_IN,   abc(3'd0, 3'd0, 3'd2), 8'h11, 1'b1);
    send_insn(OP_DIV,  abc(3'd1, 3'd1, 3'd0), 8'h00, 1'b0);
    send_insn(OP_UNDEF_F, OPND_W'($urandom), 8'h00, 1'b0);
    send_insn(OP_HALT, OPND_W'($urandom), 8'h00, 1'b0);
  endtask

  // The receiver stalls at random, save for the steady stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !steady && ($urandom_range(0, 99) < 33);
    end
  end

  // Result checking on the falling edge: a word handed over here is taken at
  // the next rising edge, and every field is compared with the oldest
  // expectation.
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word, status", '0, WORD_W'(out_status));
      end else begin
        want_res = pending_results.pop_front();
        if (out_out_valid !== want_res.out_vld)
          report_mismatch("out_valid", WORD_W'(want_res.out_vld), WORD_W'(out_out_valid));
        if (out_out_byte !== want_res.out_byte)
          report_mismatch("out_byte", WORD_W'(want_res.out_byte), WORD_W'(out_out_byte));
        if (out_write_en !== want_res.wen)
          report_mismatch("write_en", WORD_W'(want_res.wen), WORD_W'(out_write_en));
        if (out_write_index !== want_res.widx)
          report_mismatch("write_index", WORD_W'(want_res.widx), WORD_W'(out_write_index));
        if (out_write_value !== want_res.wval)
          report_mismatch("write_value", want_res.wval, out_write_value);
        if (out_status !== want_res.status)
          report_mismatch("status", WORD_W'(want_res.status), WORD_W'(out_status));
      end
      result_count++;
    end
  end

  // Watchdog: the run is hung once neither channel has moved a word for too
  // long.
  always @(negedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("um_register_alu_execute regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_load_immediates();
    test_arithmetic();
    test_cond_move();
    test_byte_io();
    test_unsupported_ops();
    test_random_stream();
    test_halt();
    await_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("um_register_alu_execute regression: pass");
    end else begin
      $display("um_register_alu_execute regression: fail");
    end
    $finish;
  end

endmodule
